/* hdl/fic_pkg.sv */
// fic_pkg: types, codes and the CRC byte-fold function of the frame integrity checker.
// No dependencies; imported by frame_integrity_checker, fic_front and fic_back.
package fic_pkg;

   localparam int COUNTER_BITS_DEFAULT = 32;
   localparam int CMD_DEPTH_DEFAULT    = 4;
   localparam int RSP_DEPTH_DEFAULT    = 4;
   localparam int CSR_INDEX_BITS       = 8;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPECTED_SIZE = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRC_PERIOD    = 8'd1;

   // Item kinds
   localparam logic REQ_HEADER = 1'b0;
   localparam logic REQ_DATA   = 1'b1;

   // CRC verdicts
   localparam logic [1:0] CRC_NOT_SAMPLED = 2'd0;
   localparam logic [1:0] CRC_ABSENT      = 2'd1;
   localparam logic [1:0] CRC_MATCH       = 2'd2;
   localparam logic [1:0] CRC_MISMATCH    = 2'd3;

   localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        req_type;
      logic        has_payload;
      logic        length_known;
      logic [31:0] length_reported;
      logic        crc_given;
      logic [31:0] reported_crc;
      logic [7:0]  data_byte;
      logic        last_byte;
   } req_item_type;

   typedef struct packed {
      logic [31:0] frame_total;
      logic        size_fault;
      logic [1:0]  crc_status;
      logic [31:0] computed_crc;
      logic [31:0] size_fault_total;
      logic [31:0] crc_checked_total;
      logic [31:0] crc_bad_total;
      logic [31:0] crc_missing_total;
   } rsp_item_type;

   // Classified command passed from the front end to the back end
   typedef struct packed {
      logic        is_data;
      logic        has_payload;
      logic        crc_given;
      logic        size_fault;
      logic        no_limit;
      logic [31:0] length;
      logic [31:0] crc;
      logic [7:0]  data_byte;
      logic        last_byte;
   } cmd_type;

   // Reflected CRC-32, one byte
   function automatic logic [31:0] crc32_fold_byte(input logic [31:0] crc,
                                                   input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* hdl/frame_integrity_checker.sv */
// frame_integrity_checker: top level; configuration registers, front end, command queue,
// back end and result queue. Depends on fic_pkg, fic_front, fic_fifo and fic_back.
//
// Path: an item is registered in the command queue and handled by the back end; a result
//   that it causes is registered in the result queue and is then on rsp_data, empty low.
// Throughput: one item per cycle, headers and data bytes alike, unless a queue is full;
//   the back end updates the frame state and folds one CRC byte per cycle.
// Reset (synchronous, active high): empties both queues, clears all counters and frame
//   state, presets the CRC accumulator to all ones, expected_size to 0, crc_period to 1.
module frame_integrity_checker import fic_pkg::*; #(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT,
   parameter int CMD_DEPTH    = CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH    = RSP_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // input item channel
   input  logic                      push,
   output logic                      full,
   input  req_item_type              req_data,
   // result channel
   output logic                      empty,
   input  logic                      pop,
   output rsp_item_type              rsp_data,
   // configuration write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]               csr_wdata
);

   logic [31:0]  expected_size_ff, expected_size_in;
   logic [31:0]  crc_period_ff,    crc_period_in;

   cmd_type      front_cmd;
   cmd_type      back_cmd;
   logic         cmd_empty;
   logic         cmd_pop;
   logic         rsp_full;
   logic         rsp_push;
   rsp_item_type back_rsp;

   // Configuration: always ready; a write to an unknown index is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      expected_size_in = expected_size_ff;
      crc_period_in    = crc_period_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EXPECTED_SIZE: expected_size_in = csr_wdata;
            CSR_CRC_PERIOD:    crc_period_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_size_ff <= 32'd0;
         crc_period_ff    <= 32'd1;
      end else begin
         expected_size_ff <= expected_size_in;
         crc_period_ff    <= crc_period_in;
      end
   end

   // Front end: classify each transfer and queue it as a command.
   fic_front u_front (
      .req_item      (req_data),
      .expected_size (expected_size_ff),
      .cmd           (front_cmd)
   );

   // Command queue: full here is what the source sees; the back end may stall
   // on a full result queue without blocking intake until this fills.
   fic_fifo #(
      .item_type (cmd_type),
      .DEPTH     (CMD_DEPTH)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (front_cmd),
      .full     (full),
      .pop      (cmd_pop),
      .item_out (back_cmd),
      .empty    (cmd_empty)
   );

   // Back end: one command per cycle whenever the result queue has room.
   fic_back #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .crc_period (crc_period_ff),
      .cmd        (back_cmd),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (back_rsp)
   );

   // Result queue: hold finished results until the sink takes them.
   fic_fifo #(
      .item_type (rsp_item_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .item_in  (back_rsp),
      .full     (rsp_full),
      .pop      (pop),
      .item_out (rsp_data),
      .empty    (empty)
   );

endmodule

/* hdl/fic_fifo.sv */
// fic_fifo: small first-in first-out queue of any packed item type.
// Standalone; used for the command queue and the result queue.
module fic_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type item_in,
   output logic     full,
   input  logic     pop,
   output item_type item_out,
   output logic     empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   item_type              mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

/* hdl/fic_front.sv */
// fic_front: classifies an incoming item into a back-end command.
// Depends on fic_pkg; settles the stateless size verdict and byte-limit mode.
module fic_front import fic_pkg::*; (
   input  req_item_type req_item,
   input  logic [31:0]  expected_size,
   output cmd_type      cmd
);

   always_comb begin
      cmd.is_data     = (req_item.req_type == REQ_DATA);
      cmd.has_payload = req_item.has_payload;
      cmd.crc_given   = req_item.crc_given;
      cmd.size_fault  = (expected_size != 32'd0) && req_item.length_known &&
                        (req_item.length_reported != expected_size);
      // no limit when the length is unknown or zero
      cmd.no_limit    = !(req_item.length_known && (req_item.length_reported != 32'd0));
      cmd.length      = req_item.length_reported;
      cmd.crc         = req_item.reported_crc;
      cmd.data_byte   = req_item.data_byte;
      cmd.last_byte   = req_item.last_byte;
   end

endmodule

/* hdl/fic_back.sv */
// fic_back: executes commands one per cycle while the result queue has room:
// frame counting, sampling phase, CRC folding, verdicts and totals. Depends on fic_pkg.
module fic_back import fic_pkg::*; #(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [31:0]  crc_period,
   input  cmd_type      cmd,
   input  logic         cmd_empty,
   output logic         cmd_pop,
   input  logic         rsp_full,
   output logic         rsp_push,
   output rsp_item_type rsp_item
);

   typedef logic [COUNTER_BITS-1:0] count_type;

   count_type   frame_count_ff,      frame_count_in;
   count_type   size_fault_count_ff, size_fault_count_in;
   count_type   checked_count_ff,    checked_count_in;
   count_type   mismatch_count_ff,   mismatch_count_in;
   count_type   missing_count_ff,    missing_count_in;
   logic [31:0] sample_phase_ff,     sample_phase_in;
   logic [31:0] crc_accum_ff,        crc_accum_in;
   logic [31:0] bytes_seen_ff,       bytes_seen_in;
   logic [31:0] byte_limit_ff,       byte_limit_in;
   logic [31:0] frame_crc_ff,        frame_crc_in;
   logic        pend_ff,             pend_in;
   logic        size_flag_ff,        size_flag_in;
   logic        no_limit_ff,         no_limit_in;

   logic        fire;
   logic        emit;
   logic [31:0] phase_next;
   logic        sampled;
   logic [31:0] folded;
   logic        take_byte;

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   assign fire    = !cmd_empty && !rsp_full;
   assign cmd_pop = fire;

   assign phase_next = sample_phase_ff + 32'd1;
   assign sampled    = (crc_period != 32'd0) && (phase_next >= crc_period);
   assign take_byte  = no_limit_ff || (bytes_seen_ff < byte_limit_ff);
   assign folded     = crc32_fold_byte(crc_accum_ff, cmd.data_byte);

   always_comb begin
      frame_count_in      = frame_count_ff;
      size_fault_count_in = size_fault_count_ff;
      checked_count_in    = checked_count_ff;
      mismatch_count_in   = mismatch_count_ff;
      missing_count_in    = missing_count_ff;
      sample_phase_in     = sample_phase_ff;
      crc_accum_in        = crc_accum_ff;
      bytes_seen_in       = bytes_seen_ff;
      byte_limit_in       = byte_limit_ff;
      frame_crc_in        = frame_crc_ff;
      pend_in             = pend_ff;
      size_flag_in        = size_flag_ff;
      no_limit_in         = no_limit_ff;
      emit                     = 1'b0;
      rsp_item.size_fault      = 1'b0;
      rsp_item.crc_status      = CRC_NOT_SAMPLED;
      rsp_item.computed_crc    = 32'd0;

      if (fire && !cmd.is_data) begin
         // header: any unfinished frame is dropped
         pend_in         = 1'b0;
         frame_count_in  = sat_inc(frame_count_ff);
         if (cmd.size_fault) begin
            size_fault_count_in = sat_inc(size_fault_count_ff);
         end
         sample_phase_in = sampled ? 32'd0 : phase_next;
         rsp_item.size_fault = cmd.size_fault;
         if (!sampled || !cmd.has_payload) begin
            emit = 1'b1;
         end else if (!cmd.crc_given) begin
            emit                = 1'b1;
            missing_count_in    = sat_inc(missing_count_ff);
            rsp_item.crc_status = CRC_ABSENT;
         end else begin
            crc_accum_in  = CRC32_INIT;
            bytes_seen_in = 32'd0;
            frame_crc_in  = cmd.crc;
            byte_limit_in = cmd.no_limit ? 32'd0 : cmd.length;
            pend_in       = 1'b1;
            no_limit_in   = cmd.no_limit;
            size_flag_in  = cmd.size_fault;
         end
      end else if (fire && pend_ff) begin
         if (take_byte) begin
            crc_accum_in = folded;
            if (bytes_seen_ff != 32'hFFFF_FFFF) begin
               bytes_seen_in = bytes_seen_ff + 32'd1;
            end
         end
         if (cmd.last_byte) begin
            emit                  = 1'b1;
            pend_in               = 1'b0;
            checked_count_in      = sat_inc(checked_count_ff);
            rsp_item.size_fault   = size_flag_ff;
            rsp_item.computed_crc = crc_accum_in;
            if (crc_accum_in == frame_crc_ff) begin
               rsp_item.crc_status = CRC_MATCH;
            end else begin
               rsp_item.crc_status = CRC_MISMATCH;
               mismatch_count_in   = sat_inc(mismatch_count_ff);
            end
         end
      end

      rsp_item.frame_total       = 32'(frame_count_in);
      rsp_item.size_fault_total  = 32'(size_fault_count_in);
      rsp_item.crc_checked_total = 32'(checked_count_in);
      rsp_item.crc_bad_total     = 32'(mismatch_count_in);
      rsp_item.crc_missing_total = 32'(missing_count_in);
   end

   assign rsp_push = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff      <= '0;
         size_fault_count_ff <= '0;
         checked_count_ff    <= '0;
         mismatch_count_ff   <= '0;
         missing_count_ff    <= '0;
         sample_phase_ff     <= '0;
         crc_accum_ff        <= CRC32_INIT;
         bytes_seen_ff       <= '0;
         byte_limit_ff       <= '0;
         frame_crc_ff        <= '0;
         pend_ff             <= 1'b0;
         size_flag_ff        <= 1'b0;
         no_limit_ff         <= 1'b0;
      end else begin
         frame_count_ff      <= frame_count_in;
         size_fault_count_ff <= size_fault_count_in;
         checked_count_ff    <= checked_count_in;
         mismatch_count_ff   <= mismatch_count_in;
         missing_count_ff    <= missing_count_in;
         sample_phase_ff     <= sample_phase_in;
         crc_accum_ff        <= crc_accum_in;
         bytes_seen_ff       <= bytes_seen_in;
         byte_limit_ff       <= byte_limit_in;
         frame_crc_ff        <= frame_crc_in;
         pend_ff             <= pend_in;
         size_flag_ff        <= size_flag_in;
         no_limit_ff         <= no_limit_in;
      end
   end

   a_header_counts: assert property (@(posedge clock) disable iff (reset)
      fire && !cmd.is_data |=> frame_count_ff != '0)
      else $error("frame counter zero after a header");

   a_data_verdict: assert property (@(posedge clock) disable iff (reset)
      emit && cmd.is_data |->
         rsp_item.crc_status == CRC_MATCH || rsp_item.crc_status == CRC_MISMATCH)
      else $error("data result without a CRC verdict");

   a_unsampled_crc_zero: assert property (@(posedge clock) disable iff (reset)
      emit && (rsp_item.crc_status == CRC_NOT_SAMPLED ||
               rsp_item.crc_status == CRC_ABSENT) |-> rsp_item.computed_crc == 32'd0)
      else $error("computed CRC set on an unchecked frame");

   a_result_closes_frame: assert property (@(posedge clock) disable iff (reset)
      emit |=> !pend_ff)
      else $error("frame still pending after its result");

endmodule
